// File: src/slx_pkg.sv
// Shared types, constants and character-class functions for the source text lexer.
// Used by every module of the lexer; depends on nothing else.
package slx_pkg;

    localparam int POS_BITS    = 32;
    localparam int OUT_BITS    = 32;
    localparam int KIND_BITS   = 5;
    localparam int KEEP_CHARS  = 6;
    localparam int LEAD_IDX_BITS = $clog2(KEEP_CHARS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [POS_BITS-1:0]           t_pos;
    typedef logic [KIND_BITS-1:0]          t_kind;
    typedef logic [7:0]                    t_byte;
    typedef logic [KEEP_CHARS-1:0][7:0]    t_chars;

    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_EOS  = 1'b1;

    localparam t_kind KIND_EOF       = 5'd0;
    localparam t_kind KIND_FLOAT     = 5'd1;
    localparam t_kind KIND_INTEGER   = 5'd2;
    localparam t_kind KIND_IDENT     = 5'd3;
    localparam t_kind KIND_STAR      = 5'd4;
    localparam t_kind KIND_COLON     = 5'd5;
    localparam t_kind KIND_EQUAL     = 5'd6;
    localparam t_kind KIND_LBRACE    = 5'd7;
    localparam t_kind KIND_LPAREN    = 5'd8;
    localparam t_kind KIND_MINUS     = 5'd9;
    localparam t_kind KIND_PLUS      = 5'd10;
    localparam t_kind KIND_RBRACE    = 5'd11;
    localparam t_kind KIND_RPAREN    = 5'd12;
    localparam t_kind KIND_SEMI      = 5'd13;
    localparam t_kind KIND_SLASH     = 5'd14;
    localparam t_kind KIND_KW_FN     = 5'd15;
    localparam t_kind KIND_KW_PUB    = 5'd16;
    localparam t_kind KIND_KW_RETURN = 5'd17;
    localparam t_kind KIND_KW_VAR    = 5'd18;
    localparam t_kind KIND_UNKNOWN   = 5'd19;

    localparam t_byte CH_DOT = ".";

    typedef struct packed {
        t_kind               token_kind;
        logic [OUT_BITS-1:0] start_pos;
        logic [OUT_BITS-1:0] token_length;
        logic                last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic logic is_alpha(input t_byte c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input t_byte c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input t_byte c);
        return c == " " || c == 8'h0D || c == 8'h0A;
    endfunction

    // Returns KIND_EOF when the byte is not an operator.
    function automatic t_kind op_kind(input t_byte c);
        t_kind k;
        unique case (c)
            "*":     k = KIND_STAR;
            ":":     k = KIND_COLON;
            "=":     k = KIND_EQUAL;
            "{":     k = KIND_LBRACE;
            "(":     k = KIND_LPAREN;
            "-":     k = KIND_MINUS;
            "+":     k = KIND_PLUS;
            "}":     k = KIND_RBRACE;
            ")":     k = KIND_RPAREN;
            ";":     k = KIND_SEMI;
            "/":     k = KIND_SLASH;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

    function automatic t_kind keyword_kind(input t_chars lc, input t_pos len);
        t_kind k;
        if (len == t_pos'(2) && lc[0] == "f" && lc[1] == "n") begin
            k = KIND_KW_FN;
        end else if (len == t_pos'(3) && lc[0] == "p" && lc[1] == "u" && lc[2] == "b") begin
            k = KIND_KW_PUB;
        end else if (len == t_pos'(6) && lc[0] == "r" && lc[1] == "e" && lc[2] == "t"
                     && lc[3] == "u" && lc[4] == "r" && lc[5] == "n") begin
            k = KIND_KW_RETURN;
        end else if (len == t_pos'(3) && lc[0] == "v" && lc[1] == "a" && lc[2] == "r") begin
            k = KIND_KW_VAR;
        end else begin
            k = KIND_IDENT;
        end
        return k;
    endfunction

endpackage

// File: src/slx_if.sv
// Handshake interfaces for the lexer: source bytes in, tokens out.
// Depends on slx_pkg for field widths.
interface slx_char_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] char_code;

    modport source (output valid, output req_type, output char_code, input ready);
    modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface slx_token_if;
    logic                         valid;
    logic                         ready;
    logic [slx_pkg::KIND_BITS-1:0] token_kind;
    logic [slx_pkg::OUT_BITS-1:0]  start_pos;
    logic [slx_pkg::OUT_BITS-1:0]  token_length;
    logic                         last_of_run;

    modport source (output valid, output token_kind, output start_pos, output token_length,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input start_pos, input token_length,
                    input last_of_run, output ready);
endinterface

// File: src/source_text_lexer.sv
// Top level of the byte-serial source text lexer: scanner plus result queue.
// Depends on slx_pkg, slx_if, slx_scan and slx_outq.
//
//   Channel      Dir  Payload                                            Role
//   i_char_if    in   req_type, char_code                                one byte or end of source
//   o_token_if   out  token_kind, start_pos, token_length, last_of_run   one token
//
// An item is registered on acceptance and scanned from that register when the queue has
// room; its tokens are then registered in the queue. One item is accepted every cycle
// while the queue has room; the four-entry queue takes both tokens of an item at once.
// Input ready drops only while the queue holds more than two tokens.
// Reset is synchronous and active low and returns the scanner to the begin mode.
module source_text_lexer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slx_char_if.sink     i_char_if,
    slx_token_if.source  o_token_if
);

    slx_pkg::t_push   push;
    slx_pkg::t_result head;
    logic             room;

    slx_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_char_if.valid),
        .i_req_type  (i_char_if.req_type),
        .i_char_code (i_char_if.char_code),
        .i_room      (room),
        .o_ready     (i_char_if.ready),
        .o_push      (push)
    );

    slx_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ready (o_token_if.ready),
        .o_room  (room),
        .o_valid (o_token_if.valid),
        .o_data  (head)
    );

    assign o_token_if.token_kind   = head.token_kind;
    assign o_token_if.start_pos    = head.start_pos;
    assign o_token_if.token_length = head.token_length;
    assign o_token_if.last_of_run  = head.last_of_run;

endmodule

// File: src/slx_scan.sv
// Input register and scanner state machine; turns each byte into zero, one or two tokens.
// Depends on slx_pkg.
module slx_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_req_type,
    input  logic [7:0]          i_char_code,
    input  logic                i_room,
    output logic                o_ready,
    output slx_pkg::t_push      o_push
);

    typedef enum logic [1:0] {
        MODE_BEGIN,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_HALTED
    } t_mode;

    logic                 r_in_vld;
    logic                 r_req;
    slx_pkg::t_byte       r_chr;
    t_mode                r_mode,  n_mode;
    slx_pkg::t_pos        r_start, n_start;
    slx_pkg::t_pos        r_pos,   n_pos;
    slx_pkg::t_chars      r_lead,  n_lead;
    logic                 r_saw,   n_saw;

    logic                 advance;
    logic                 pending;
    logic                 known;
    slx_pkg::t_kind       op;
    slx_pkg::t_pos        pend_len;
    slx_pkg::t_result     pend_res;
    slx_pkg::t_result     here_res;
    slx_pkg::t_push       push;

    assign advance = r_in_vld && i_room;
    assign o_ready = !r_in_vld || i_room;

    always_comb begin
        n_mode   = r_mode;
        n_start  = r_start;
        n_pos    = r_pos;
        n_lead   = r_lead;
        n_saw    = r_saw;
        push     = '0;

        pending  = (r_mode == MODE_IDENT) || (r_mode == MODE_NUMBER);
        op       = slx_pkg::op_kind(r_chr);
        known    = slx_pkg::is_alpha(r_chr) || slx_pkg::is_digit(r_chr)
                   || slx_pkg::is_space(r_chr) || r_chr == slx_pkg::CH_DOT
                   || op != slx_pkg::KIND_EOF;
        pend_len = r_pos - r_start;

        pend_res.token_kind   = (r_mode == MODE_IDENT) ? slx_pkg::keyword_kind(r_lead, pend_len)
                                : (r_saw ? slx_pkg::KIND_FLOAT : slx_pkg::KIND_INTEGER);
        pend_res.start_pos    = slx_pkg::OUT_BITS'(r_start);
        pend_res.token_length = slx_pkg::OUT_BITS'(pend_len);
        pend_res.last_of_run  = 1'b0;

        here_res.token_kind   = op;
        here_res.start_pos    = slx_pkg::OUT_BITS'(r_pos);
        here_res.token_length = slx_pkg::OUT_BITS'(1);
        here_res.last_of_run  = 1'b1;

        if (r_mode != MODE_HALTED) begin
            if (r_req == slx_pkg::REQ_EOS) begin
                here_res.token_kind   = slx_pkg::KIND_EOF;
                here_res.token_length = '0;
                if (pending) begin
                    push.count  = 2'd2;
                    push.first  = pend_res;
                    push.second = here_res;
                end else begin
                    push.count  = 2'd1;
                    push.first  = here_res;
                end
                n_mode  = MODE_BEGIN;
                n_start = '0;
                n_pos   = '0;
                n_lead  = '0;
                n_saw   = 1'b0;
            end else if (!known) begin
                here_res.token_kind = slx_pkg::KIND_UNKNOWN;
                push.count = 2'd1;
                push.first = here_res;
                n_mode     = MODE_HALTED;
            end else if (r_mode == MODE_IDENT
                         && (slx_pkg::is_alpha(r_chr) || slx_pkg::is_digit(r_chr))) begin
                if (pend_len < slx_pkg::t_pos'(slx_pkg::KEEP_CHARS)) begin
                    n_lead[pend_len[slx_pkg::LEAD_IDX_BITS-1:0]] = r_chr;
                end
                n_pos = r_pos + slx_pkg::t_pos'(1);
            end else if (r_mode == MODE_NUMBER
                         && (slx_pkg::is_digit(r_chr) || r_chr == slx_pkg::CH_DOT)) begin
                if (r_chr == slx_pkg::CH_DOT) begin
                    n_saw = 1'b1;
                end
                n_pos = r_pos + slx_pkg::t_pos'(1);
            end else begin
                // The byte closes any pending token and is then scanned from the begin mode.
                n_mode = MODE_BEGIN;
                if (op != slx_pkg::KIND_EOF) begin
                    if (pending) begin
                        push.count  = 2'd2;
                        push.first  = pend_res;
                        push.second = here_res;
                    end else begin
                        push.count  = 2'd1;
                        push.first  = here_res;
                    end
                end else if (pending) begin
                    push.count             = 2'd1;
                    push.first             = pend_res;
                    push.first.last_of_run = 1'b1;
                end
                if (slx_pkg::is_alpha(r_chr)) begin
                    n_mode    = MODE_IDENT;
                    n_start   = r_pos;
                    n_lead    = '0;
                    n_lead[0] = r_chr;
                end else if (slx_pkg::is_digit(r_chr)) begin
                    n_mode  = MODE_NUMBER;
                    n_start = r_pos;
                    n_saw   = 1'b0;
                end
                n_pos = r_pos + slx_pkg::t_pos'(1);
            end
        end

        o_push = push;
        if (!advance) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_mode   <= MODE_BEGIN;
            r_start  <= '0;
            r_pos    <= '0;
            r_lead   <= '0;
            r_saw    <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (advance) begin
                r_mode  <= n_mode;
                r_start <= n_start;
                r_pos   <= n_pos;
                r_lead  <= n_lead;
                r_saw   <= n_saw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req_type;
            r_chr <= i_char_code;
        end
    end

endmodule

// File: src/slx_outq.sv
// Small result queue that takes up to two tokens per cycle and delivers one per cycle while the output is ready.
// Depends on slx_pkg.
module slx_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  slx_pkg::t_push      i_push,
    input  logic                i_ready,
    output logic                o_room,
    output logic                o_valid,
    output slx_pkg::t_result    o_data
);

    slx_pkg::t_result                  r_mem [slx_pkg::QUEUE_DEPTH];
    logic [slx_pkg::QPTR_BITS-1:0]     r_wr_ptr;
    logic [slx_pkg::QPTR_BITS-1:0]     r_rd_ptr;
    logic [slx_pkg::QCNT_BITS-1:0]     r_count;
    logic [slx_pkg::QPTR_BITS-1:0]     wr_next;
    logic                              pop;

    assign o_valid = r_count != '0;
    assign pop     = o_valid && i_ready;
    assign o_room  = r_count <= slx_pkg::QCNT_BITS'(slx_pkg::QUEUE_DEPTH - 2);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_next = r_wr_ptr + slx_pkg::QPTR_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + slx_pkg::QPTR_BITS'(i_push.count);
            r_rd_ptr <= r_rd_ptr + slx_pkg::QPTR_BITS'(pop);
            r_count  <= r_count + slx_pkg::QCNT_BITS'(i_push.count)
                        - slx_pkg::QCNT_BITS'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

endmodule

// File: src/slx_checker.sv
// Port-level checks on the lexer's tokens and reset behavior, bound to the top level.
// Depends on slx_pkg and source_text_lexer.
module slx_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_ready,
    input  logic                         i_out_valid,
    input  logic [slx_pkg::KIND_BITS-1:0] i_kind,
    input  logic [slx_pkg::OUT_BITS-1:0]  i_length,
    input  logic                         i_last
);

    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("token shown right after reset");

    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == slx_pkg::KIND_EOF |-> i_length == '0 && i_last)
        else $error("end-of-source token malformed");

    a_unknown_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == slx_pkg::KIND_UNKNOWN
        |-> i_length == slx_pkg::OUT_BITS'(1) && i_last)
        else $error("unknown-byte token malformed");

    a_operator_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind >= slx_pkg::KIND_STAR && i_kind <= slx_pkg::KIND_SLASH
        |-> i_length == slx_pkg::OUT_BITS'(1) && i_last)
        else $error("operator token length not one");

endmodule

bind source_text_lexer slx_checker u_slx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_char_if.ready),
    .i_out_valid (o_token_if.valid),
    .i_kind      (o_token_if.token_kind),
    .i_length    (o_token_if.token_length),
    .i_last      (o_token_if.last_of_run)
);
